### rtl/core/spq_pkg.sv
// Shared constants, codes and types of the sorted priority queue.
`default_nettype none
package spq_pkg;

   localparam int DEPTH   = 16;
   localparam int VALUE_W = 32;
   localparam int COUNT_W = $clog2(DEPTH + 1);
   localparam int IDX_W   = $clog2(DEPTH);
   localparam int REQ_W   = 3;
   localparam int STAT_W  = 2;

   localparam logic [REQ_W-1:0] REQ_INSERT      = 3'd0;
   localparam logic [REQ_W-1:0] REQ_READ_HEAD   = 3'd1;
   localparam logic [REQ_W-1:0] REQ_REMOVE_HEAD = 3'd2;
   localparam logic [REQ_W-1:0] REQ_READ_TAIL   = 3'd3;
   localparam logic [REQ_W-1:0] REQ_CLEAR       = 3'd4;

   localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
   localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
   localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

   typedef logic signed [VALUE_W-1:0] spq_value_type;

   typedef struct packed {
      logic insert;
      logic shift;
   } spq_ctrl_type;

endpackage
`default_nettype wire

### rtl/core/spq_cell.sv
// One slot of the sorted chain: holds a value and moves it to or from its neighbours.
`default_nettype none
module spq_cell
   import spq_pkg::*;
(
   input  wire logic          clock,
   input  wire spq_ctrl_type  ctrl,
   input  wire spq_value_type new_value,
   input  wire spq_value_type left_value,
   input  wire logic          left_keep,
   input  wire spq_value_type right_value,
   input  wire logic          occupied,
   output spq_value_type      cell_value,
   output logic               keep
);

   spq_value_type value_ff;
   spq_value_type value_in;

   // A slot keeps its value on insert when it is occupied and not smaller than the new item.
   assign keep       = occupied && (value_ff >= new_value);
   assign cell_value = value_ff;

   always_comb begin
      value_in = value_ff;
      if (ctrl.insert && !keep) begin
         value_in = left_keep ? new_value : left_value;
      end else if (ctrl.shift) begin
         value_in = right_value;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

endmodule
`default_nettype wire

### rtl/core/sorted_priority_queue_core.sv
// Top level of the sorted priority queue: a chain of slots plus fill count and result registers.
//
//  channel   ports                                   handshake
//  request   req_type, req_value_in                  start high while busy low
//  result    rsp_value_out, rsp_status, rsp_count_out rsp_valid high for one cycle
//
// Each item takes one cycle; a new item may be taken in every cycle after reset.
// The result appears in the cycle after the item is taken and is held for one cycle.
// All slots compare against the new value in parallel, so an insert settles in one cycle.
// Reset clears the fill count and result strobe; busy is high while reset is held and for the
// first cycle after it, and never otherwise.
// The receiver cannot stall results.
`default_nettype none
module sorted_priority_queue_core
   import spq_pkg::*;
(
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       start,
   output logic                            busy,
   input  wire logic        [REQ_W-1:0]    req_type,
   input  wire logic signed [VALUE_W-1:0]  req_value_in,
   output logic                            rsp_valid,
   output logic signed [VALUE_W-1:0]       rsp_value_out,
   output logic        [STAT_W-1:0]        rsp_status,
   output logic        [4:0]               rsp_count_out
);

   logic                busy_ff;
   logic [COUNT_W-1:0]  fill_count_ff;
   logic [COUNT_W-1:0]  fill_count_in;
   logic                rsp_valid_ff;
   spq_value_type       rsp_value_ff;
   spq_value_type       rsp_value_in;
   logic [STAT_W-1:0]   rsp_status_ff;
   logic [STAT_W-1:0]   rsp_status_in;

   logic                accept;
   logic                full;
   logic                empty;
   logic [IDX_W-1:0]    tail_idx;
   spq_ctrl_type        ctrl;
   spq_value_type       cell_value [DEPTH];
   logic [DEPTH-1:0]    keep;
   logic [DEPTH-1:0]    occupied;

   assign accept   = start && !busy_ff;
   assign full     = (fill_count_ff == COUNT_W'(DEPTH));
   assign empty    = (fill_count_ff == '0);
   assign tail_idx = IDX_W'(fill_count_ff - COUNT_W'(1));

   assign ctrl.insert = accept && (req_type == REQ_INSERT) && !full;
   assign ctrl.shift  = accept && (req_type == REQ_REMOVE_HEAD) && !empty;

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      spq_value_type left_value;
      spq_value_type right_value;
      logic          left_keep;

      assign occupied[i] = (COUNT_W'(i) < fill_count_ff);

      if (i == 0) begin : g_head
         assign left_value = cell_value[0];
         assign left_keep  = 1'b1;
      end else begin : g_body
         assign left_value = cell_value[i-1];
         assign left_keep  = keep[i-1];
      end

      if (i == DEPTH - 1) begin : g_tail
         assign right_value = cell_value[i];
      end else begin : g_inner
         assign right_value = cell_value[i+1];
      end

      spq_cell u_cell (
         .clock       (clock),
         .ctrl        (ctrl),
         .new_value   (req_value_in),
         .left_value  (left_value),
         .left_keep   (left_keep),
         .right_value (right_value),
         .occupied    (occupied[i]),
         .cell_value  (cell_value[i]),
         .keep        (keep[i])
      );
   end

   always_comb begin
      fill_count_in = fill_count_ff;
      rsp_value_in  = '0;
      rsp_status_in = ST_OK;
      case (req_type)
         REQ_INSERT: begin
            if (full) begin
               rsp_status_in = ST_FULL;
            end else begin
               fill_count_in = fill_count_ff + COUNT_W'(1);
            end
         end
         REQ_READ_HEAD, REQ_REMOVE_HEAD: begin
            if (empty) begin
               rsp_status_in = ST_EMPTY;
            end else begin
               rsp_value_in = cell_value[0];
               if (req_type == REQ_REMOVE_HEAD) begin
                  fill_count_in = fill_count_ff - COUNT_W'(1);
               end
            end
         end
         REQ_READ_TAIL: begin
            if (empty) begin
               rsp_status_in = ST_EMPTY;
            end else begin
               rsp_value_in = cell_value[tail_idx];
            end
         end
         REQ_CLEAR: begin
            fill_count_in = '0;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff       <= 1'b1;
         fill_count_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         busy_ff      <= 1'b0;
         rsp_valid_ff <= accept;
         if (accept) begin
            fill_count_ff <= fill_count_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_value_ff  <= rsp_value_in;
         rsp_status_ff <= rsp_status_in;
      end
   end

   assign busy          = busy_ff;
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_value_out = rsp_value_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_count_out = 5'(fill_count_ff);

`ifndef SYNTHESIS
   a_result_follows_item: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid_ff)
      else $error("accepted item produced no result");

   a_count_bounded: assert property (@(posedge clock) disable iff (reset)
      fill_count_ff <= COUNT_W'(DEPTH))
      else $error("fill count exceeds queue depth");

   a_full_reports_depth: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff == ST_FULL) |-> (fill_count_ff == COUNT_W'(DEPTH)))
      else $error("full status reported while queue not full");

   a_head_ordered: assert property (@(posedge clock) disable iff (reset)
      (fill_count_ff >= COUNT_W'(2)) |-> (cell_value[0] >= cell_value[1]))
      else $error("head item smaller than its successor");
`endif

endmodule
`default_nettype wire

### bench/tb_sorted_priority_queue_core.sv
// Self-checking bench for the sorted priority queue core: directed and random requests.
module tb_sorted_priority_queue_core
   import spq_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int IDLE_LIMIT  = 500;
   localparam int ITEM_TARGET = 1700;

   typedef enum int {MIX_FILL, MIX_DRAIN, MIX_BALANCED, MIX_NOISE} traffic_mix_type;

   typedef struct {
      logic signed [VALUE_W-1:0] value;
      logic [STAT_W-1:0]         status;
      logic [4:0]                count;
   } queue_result_type;

   // Keeps a shadow copy of the sorted entries and the results still owed by the core.
   class SortedQueueTracker;
      logic signed [VALUE_W-1:0] slots [DEPTH];
      int                        held;
      queue_result_type          awaited [$];
      int                        failures;

      function new();
         held     = 0;
         failures = 0;
      endfunction

      function void note_request(logic [REQ_W-1:0] kind, logic signed [VALUE_W-1:0] val);
         queue_result_type r;
         int               pos;
         int               k;
         r.value  = '0;
         r.status = ST_OK;
         case (kind)
            REQ_INSERT: begin
               if (held >= DEPTH) begin
                  r.status = ST_FULL;
               end else begin
                  // Equal values stay ahead of the newcomer, so ties leave in arrival order.
                  pos = 0;
                  while (pos < held && slots[pos] >= val) pos++;
                  for (k = held; k > pos; k--) slots[k] = slots[k-1];
                  slots[pos] = val;
                  held++;
               end
            end
            REQ_READ_HEAD, REQ_REMOVE_HEAD: begin
               if (held == 0) begin
                  r.status = ST_EMPTY;
               end else begin
                  r.value = slots[0];
                  if (kind == REQ_REMOVE_HEAD) begin
                     for (k = 1; k < held; k++) slots[k-1] = slots[k];
                     held--;
                  end
               end
            end
            REQ_READ_TAIL: begin
               if (held == 0) r.status = ST_EMPTY;
               else r.value = slots[held-1];
            end
            REQ_CLEAR: begin
               held = 0;
            end
            default: begin
            end
         endcase
         r.count = 5'(held);
         awaited.push_back(r);
      endfunction

      function void check_result(logic signed [VALUE_W-1:0] value, logic [STAT_W-1:0] status,
                                 logic [4:0] count);
         queue_result_type r;
         if (awaited.size() == 0) begin
            $error("result with nothing outstanding: value %0d status %0d count %0d",
                   value, status, count);
            failures++;
            return;
         end
         r = awaited.pop_front();
         if (value !== r.value) begin
            $error("rsp_value_out: expected %0d, got %0d", r.value, value);
            failures++;
         end
         if (status !== r.status) begin
            $error("rsp_status: expected %0d, got %0d", r.status, status);
            failures++;
         end
         if (count !== r.count) begin
            $error("rsp_count_out: expected %0d, got %0d", r.count, count);
            failures++;
         end
      endfunction

      function int pending();
         return awaited.size();
      endfunction
   endclass

   logic                      clock;
   logic                      reset;
   logic                      start;
   logic                      busy;
   logic [REQ_W-1:0]          req_type;
   logic signed [VALUE_W-1:0] req_value_in;
   logic                      rsp_valid;
   logic signed [VALUE_W-1:0] rsp_value_out;
   logic [STAT_W-1:0]         rsp_status;
   logic [4:0]                rsp_count_out;

   SortedQueueTracker tracker = new();
   int                idle_cycles = 0;
   int                items_sent  = 0;

   sorted_priority_queue_core dut (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_type      (req_type),
      .req_value_in  (req_value_in),
      .rsp_valid     (rsp_valid),
      .rsp_value_out (rsp_value_out),
      .rsp_status    (rsp_status),
      .rsp_count_out (rsp_count_out)
   );

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid) tracker.check_result(rsp_value_out, rsp_status, rsp_count_out);
   end

   // Ends the run if neither side moves an item for too long.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Every path leaves start alone until the next falling edge, where it is either lowered
   // or loaded with the next item, so one item is never taken twice.
   task automatic send_request(input logic [REQ_W-1:0] kind,
                               input logic signed [VALUE_W-1:0] val, input int gap);
      if (gap > 0) begin
         @(negedge clock);
         start <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      start        <= 1'b1;
      req_type     <= kind;
      req_value_in <= val;
      do @(posedge clock); while (busy);
      tracker.note_request(kind, val);
      items_sent++;
   endtask

   task automatic wait_for_drain();
      @(negedge clock);
      start <= 1'b0;
      while (tracker.pending() != 0) @(posedge clock);
   endtask

   function automatic logic signed [VALUE_W-1:0] pick_value(bit narrow);
      int unsigned r;
      r = $urandom_range(0, 9);
      if (r == 0) return 32'sh7fffffff;
      if (r == 1) return 32'sh80000000;
      // A narrow spread makes equal values common.
      if (r <= 4 || (narrow && r <= 7)) return $signed($urandom_range(0, 8)) - 4;
      return $urandom;
   endfunction

   function automatic logic [REQ_W-1:0] pick_kind(traffic_mix_type mix);
      int unsigned r;
      r = $urandom_range(0, 99);
      case (mix)
         MIX_FILL: begin
            if (r < 75) return REQ_INSERT;
            if (r < 82) return REQ_READ_HEAD;
            if (r < 89) return REQ_READ_TAIL;
            if (r < 97) return REQ_REMOVE_HEAD;
            if (r < 99) return REQ_CLEAR;
         end
         MIX_DRAIN: begin
            if (r < 20) return REQ_INSERT;
            if (r < 30) return REQ_READ_HEAD;
            if (r < 40) return REQ_READ_TAIL;
            if (r < 97) return REQ_REMOVE_HEAD;
         end
         MIX_BALANCED: begin
            if (r < 40) return REQ_INSERT;
            if (r < 55) return REQ_READ_HEAD;
            if (r < 70) return REQ_READ_TAIL;
            if (r < 93) return REQ_REMOVE_HEAD;
            if (r < 96) return REQ_CLEAR;
         end
         default: begin
            if (r < 30) return REQ_CLEAR;
            if (r >= 60) return REQ_W'($urandom_range(0, 4));
         end
      endcase
      // Unused request codes.
      return REQ_W'($urandom_range(5, 7));
   endfunction

   initial begin
      traffic_mix_type mix;
      int              burst_len;
      bit              quiet;
      bit              narrow;
      int              gap;

      reset        = 1'b1;
      start        = 1'b0;
      req_type     = REQ_INSERT;
      req_value_in = '0;
      repeat (8) @(negedge clock);
      reset <= 1'b0;

      // Empty queue, unused codes, extreme and equal values, both ends and clear.
      send_request(REQ_READ_HEAD, 0, 0);
      send_request(REQ_REMOVE_HEAD, 0, 0);
      send_request(REQ_READ_TAIL, 0, 0);
      send_request(3'd5, 32'sh7fffffff, 0);
      send_request(3'd6, -1, 1);
      send_request(3'd7, 32'sh80000000, 0);
      send_request(REQ_INSERT, 32'sh7fffffff, 0);
      send_request(REQ_INSERT, 32'sh80000000, 0);
      send_request(REQ_INSERT, 0, 2);
      send_request(REQ_INSERT, 0, 0);
      send_request(REQ_INSERT, -1, 0);
      send_request(REQ_READ_HEAD, 0, 0);
      send_request(REQ_READ_TAIL, 0, 0);
      send_request(REQ_REMOVE_HEAD, 0, 0);
      send_request(REQ_REMOVE_HEAD, 0, 0);
      send_request(REQ_READ_TAIL, 0, 0);
      send_request(REQ_CLEAR, 0, 0);
      send_request(REQ_READ_HEAD, 0, 0);
      wait_for_drain();

      while (items_sent < ITEM_TARGET) begin
         case ($urandom_range(0, 9))
            0, 1, 2, 3: mix = MIX_FILL;
            4, 5, 6:    mix = MIX_DRAIN;
            7, 8:       mix = MIX_BALANCED;
            default:    mix = MIX_NOISE;
         endcase
         burst_len = $urandom_range(4, 30);
         quiet     = ($urandom_range(0, 3) == 0);
         narrow    = $urandom_range(0, 1);
         repeat (burst_len) begin
            gap = quiet ? 0 : $urandom_range(0, 11);
            send_request(pick_kind(mix), pick_value(narrow), gap);
         end
         if ($urandom_range(0, 7) == 0) wait_for_drain();
      end

      @(negedge clock);
      start <= 1'b0;
      while (tracker.pending() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      if (tracker.pending() != 0) begin
         $error("%0d results never arrived", tracker.pending());
         tracker.failures++;
      end
      if (tracker.failures == 0) $display("== PASS ==");
      else $display("== FAIL ==");
      $finish;
   end

endmodule

### files.f
rtl/core/spq_pkg.sv
rtl/core/spq_cell.sv
rtl/core/sorted_priority_queue_core.sv
bench/tb_sorted_priority_queue_core.sv
